FILE: rtl/core/pdpt_pkg.sv
// shared types, constants and hash functions of the path distance predictor table
package pdpt_pkg;

    localparam int SET_IDX_BITS = 6;
    localparam int WAYS         = 4;
    localparam int TAG_WIDTH    = 10;
    localparam int CONF_BITS    = 4;

    localparam int PC_BITS    = 64;
    localparam int HASH_BITS  = 16;
    localparam int DIST_BITS  = 8;
    localparam int STAMP_BITS = 32;
    localparam int CFG_BITS   = 4;
    localparam int KIND_BITS  = 2;

    localparam int NUM_SETS   = 1 << SET_IDX_BITS;
    localparam int WAY_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CONF_MAX   = (1 << CONF_BITS) - 1;

    localparam int SET_CHUNKS = (PC_BITS + SET_IDX_BITS - 1) / SET_IDX_BITS;
    localparam int SET_PAD    = SET_CHUNKS * SET_IDX_BITS;
    localparam int TAG_CHUNKS = (PC_BITS + TAG_WIDTH - 1) / TAG_WIDTH;
    localparam int TAG_PAD    = TAG_CHUNKS * TAG_WIDTH;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_PREDICT  = 2'd0,
        KIND_TRAIN    = 2'd1,
        KIND_FEEDBACK = 2'd2,
        KIND_CLEAR    = 2'd3
    } kind_t;

    typedef struct packed {
        logic [TAG_WIDTH-1:0]  tag;
        logic [DIST_BITS-1:0]  distance;
        logic [CONF_BITS-1:0]  conf;
        logic [STAMP_BITS-1:0] stamp;
    } entry_t;

    typedef entry_t [WAYS-1:0] row_t;

    localparam int ROW_BITS = $bits(row_t);

    typedef struct packed {
        logic                hit;
        logic [WAY_BITS-1:0] hit_way;
        logic [WAY_BITS-1:0] victim_way;
    } lookup_t;

    function automatic logic [SET_IDX_BITS-1:0] fold_set(
        input logic [PC_BITS-1:0]   pc,
        input logic [HASH_BITS-1:0] hash
    );
        logic [SET_PAD-1:0]      v;
        logic [SET_IDX_BITS-1:0] f;
        v = SET_PAD'(pc ^ (pc >> 2) ^ (pc >> 5) ^ PC_BITS'(hash));
        f = '0;
        for (int i = 0; i < SET_CHUNKS; i++) begin
            f = f ^ v[i*SET_IDX_BITS +: SET_IDX_BITS];
        end
        return f;
    endfunction

    function automatic logic [TAG_WIDTH-1:0] fold_tag(
        input logic [PC_BITS-1:0]   pc,
        input logic [HASH_BITS-1:0] hash
    );
        logic [TAG_PAD-1:0]   v;
        logic [TAG_WIDTH-1:0] f;
        v = TAG_PAD'(pc ^ (pc >> 3) ^ (pc >> 7) ^ PC_BITS'(hash));
        f = '0;
        for (int i = 0; i < TAG_CHUNKS; i++) begin
            f = f ^ v[i*TAG_WIDTH +: TAG_WIDTH];
        end
        return f;
    endfunction

    // counter load value, saturated to the counter width
    function automatic logic [CONF_BITS-1:0] conf_load(input logic [CFG_BITS-1:0] v);
        logic [CFG_BITS+CONF_BITS-1:0] w;
        w = (CFG_BITS + CONF_BITS)'(v);
        if (w > (CFG_BITS + CONF_BITS)'(CONF_MAX)) begin
            return CONF_BITS'(CONF_MAX);
        end
        return CONF_BITS'(w);
    endfunction

endpackage

FILE: rtl/core/pdpt_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module pdpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/pdpt_lookup.sv
// tag match and stamp-based victim choice over one set
module pdpt_lookup
    import pdpt_pkg::*;
(
    input  row_t                 row,
    input  logic [TAG_WIDTH-1:0] tag,
    output lookup_t              result
);

    logic [STAMP_BITS-1:0] best_stamp;

    always_comb begin
        result     = '0;
        best_stamp = row[0].stamp;
        // lowest matching way wins
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (row[w].tag == tag) begin
                result.hit     = 1'b1;
                result.hit_way = WAY_BITS'(w);
            end
        end
        // smallest stamp, ties stay with the lower way
        for (int w = 1; w < WAYS; w++) begin
            if (row[w].stamp < best_stamp) begin
                best_stamp        = row[w].stamp;
                result.victim_way = WAY_BITS'(w);
            end
        end
    end

endmodule

FILE: rtl/core/path_distance_predictor_table.sv
// top level of the path distance predictor table
//
// One tagged, set-associative table of a memory dependence predictor.
// Input channel s_*: one word per operation (predict, train, feedback, clear)
// with load pc, path hash, distance to record and the wrong/correct flag.
// Result channel m_*: exactly one word per input word, in order, carrying the
// predicted store queue distance (0 = none) and whether the tag matched.
// Config channel cfg_*: writes the 4-bit counter load value, always ready.
// Each set (all ways) is one row of a synchronous ram: the accept cycle issues
// the row read, the lookup state then matches, picks the victim and writes the
// row back while the result goes into the output register. Due to this
// read-modify-write of the row, the next word is taken only after the last
// one is written back.
// If the receiver stalls with a result still held, the next word is accepted
// and its lookup waits until the output register frees up.
// Reset (synchronous, active low) clears a per-set valid bit; an invalid row
// reads as all zero, so the table is empty at once. Clear works the same way
// and keeps the stamp counter.
module path_distance_predictor_table
    import pdpt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [KIND_BITS-1:0]  s_kind,
    input  logic [PC_BITS-1:0]    s_load_pc,
    input  logic [HASH_BITS-1:0]  s_history_hash,
    input  logic [DIST_BITS-1:0]  s_new_distance,
    input  logic                  s_was_wrong,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DIST_BITS-1:0]  m_pred_distance,
    output logic                  m_tag_hit,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_BITS-1:0]   cfg_data
);

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t                  state_reg, state_next;
    logic                    m_valid_reg, m_valid_next;
    logic [DIST_BITS-1:0]    m_pred_reg, m_pred_next;
    logic                    m_hit_reg, m_hit_next;
    logic [STAMP_BITS-1:0]   stamp_reg, stamp_next;
    logic [CFG_BITS-1:0]     max_conf_reg, max_conf_next;
    logic [NUM_SETS-1:0]     row_valid_reg, row_valid_next;
    logic                    row_ok_reg;

    kind_t                   kind_reg;
    logic [SET_IDX_BITS-1:0] set_reg;
    logic [TAG_WIDTH-1:0]    tag_reg;
    logic [DIST_BITS-1:0]    dist_reg;
    logic                    wrong_reg;

    logic                    s_fire;
    logic [SET_IDX_BITS-1:0] in_set;
    logic [TAG_WIDTH-1:0]    in_tag;
    logic [ROW_BITS-1:0]     rd_data;
    row_t                    cur_row;
    row_t                    new_row;
    lookup_t                 lk;
    logic                    out_free;
    logic                    wb;
    logic                    do_write;
    logic [WAY_BITS-1:0]     sel_way;
    entry_t                  ent;
    entry_t                  new_ent;
    logic [DIST_BITS-1:0]    pred;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign in_set = fold_set(s_load_pc, s_history_hash);
    assign in_tag = fold_tag(s_load_pc, s_history_hash);

    pdpt_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (NUM_SETS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wb && do_write),
        .wr_addr (set_reg),
        .wr_data (new_row),
        .rd_en   (s_fire),
        .rd_addr (in_set),
        .rd_data (rd_data)
    );

    // a never-written row stands for the all-zero reset contents
    assign cur_row = row_ok_reg ? row_t'(rd_data) : row_t'('0);

    pdpt_lookup u_lookup (
        .row    (cur_row),
        .tag    (tag_reg),
        .result (lk)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign wb       = (state_reg == ST_LOOKUP) && out_free;

    always_comb begin
        sel_way  = (kind_reg == KIND_TRAIN && !lk.hit) ? lk.victim_way : lk.hit_way;
        ent      = cur_row[sel_way];
        new_ent  = ent;
        do_write = 1'b0;
        pred     = '0;
        unique case (kind_reg)
            KIND_PREDICT: begin
                if (lk.hit && ent.conf != '0 && ent.distance != '0) begin
                    pred          = ent.distance;
                    new_ent.stamp = stamp_reg;
                    do_write      = 1'b1;
                end
            end
            KIND_TRAIN: begin
                new_ent.tag      = tag_reg;
                new_ent.distance = dist_reg;
                new_ent.conf     = conf_load(max_conf_reg);
                new_ent.stamp    = stamp_reg;
                do_write         = 1'b1;
            end
            KIND_FEEDBACK: begin
                if (lk.hit && ent.conf != '0) begin
                    new_ent.conf  = wrong_reg ? ent.conf - 1'b1 : conf_load(max_conf_reg);
                    new_ent.stamp = stamp_reg;
                    do_write      = 1'b1;
                end
            end
            KIND_CLEAR: begin
            end
        endcase
        new_row          = cur_row;
        new_row[sel_way] = new_ent;
    end

    always_comb begin
        state_next     = state_reg;
        m_valid_next   = m_valid_reg;
        m_pred_next    = m_pred_reg;
        m_hit_next     = m_hit_reg;
        stamp_next     = stamp_reg;
        max_conf_next  = max_conf_reg;
        row_valid_next = row_valid_reg;

        if (cfg_valid) begin
            max_conf_next = cfg_data;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (wb) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    m_pred_next  = pred;
                    m_hit_next   = (kind_reg == KIND_CLEAR) ? 1'b0 : lk.hit;
                    if (kind_reg == KIND_CLEAR) begin
                        row_valid_next = '0;
                    end else if (do_write) begin
                        row_valid_next[set_reg] = 1'b1;
                        stamp_next              = stamp_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            m_pred_reg    <= '0;
            m_hit_reg     <= 1'b0;
            stamp_reg     <= '0;
            max_conf_reg  <= CFG_BITS'(3);
            row_valid_reg <= '0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            m_pred_reg    <= m_pred_next;
            m_hit_reg     <= m_hit_next;
            stamp_reg     <= stamp_next;
            max_conf_reg  <= max_conf_next;
            row_valid_reg <= row_valid_next;
        end
    end

    // item fields captured at accept
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            kind_reg   <= kind_t'(s_kind);
            set_reg    <= in_set;
            tag_reg    <= in_tag;
            dist_reg   <= s_new_distance;
            wrong_reg  <= s_was_wrong;
            row_ok_reg <= row_valid_reg[in_set];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pred_distance = m_pred_reg;
    assign m_tag_hit       = m_hit_reg;

endmodule
